### design/ax25_afp_pkg.sv
// Package with the field widths, status codes and byte roles of the AX.25 address parser.
`default_nettype none

package ax25_afp_pkg;

    // Frame layout limits.
    localparam int ADDRESS_BYTES  = 7;
    localparam int MAX_ADDRESSES  = 10;
    localparam int MAX_INFO_BYTES = 256;
    localparam int MIN_FRAME_LEN  = 2 * ADDRESS_BYTES + 2;

    // Field widths.
    localparam int ROLE_W   = 3;
    localparam int ANUM_W   = 4;
    localparam int CHAR_W   = 7;
    localparam int SSID_W   = 4;
    localparam int DIGI_W   = 4;
    localparam int HDR_W    = 7;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;
    localparam int BIA_W    = 3;

    // Packed widths of the result beat.
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = ROLE_W + 1;

    // Byte roles.
    localparam logic [ROLE_W-1:0] ROLE_DEST    = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_SOURCE  = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_DIGI    = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_CONTROL = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_PID     = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_INFO    = 3'd5;

    // Frame status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FEW   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LONG  = 3'd4;

    // Counter limits.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [HDR_W-1:0]   HDR_MAX   = '1;
    localparam logic [COUNT_W-1:0] INFO_CAP  = COUNT_W'(MAX_INFO_BYTES);
    localparam logic [COUNT_W-1:0] INFO_RESET_LIMIT = COUNT_W'(256);

endpackage

`default_nettype wire

### design/ax25_address_field_parser.sv
// AX.25 address field parser: tags each frame byte and reports frame status on the last byte.
// Each accepted input beat is registered as its result beat in the output register.
// Throughput: one byte per cycle; a new beat is taken whenever the output register is empty
// or its beat is taken in the same cycle.
// Reset: aresetn (synchronous, active low) clears the parse state and sets the info limit to 256.
`default_nettype none

module ax25_address_field_parser
    import ax25_afp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  wire logic                 s_tlast,   // frame_last
    // Result stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [3:0] address_number, [10:4] callsign_char, [14:11] ssid_value,
    // [18:15] digipeater_count, [25:19] header_length, [28:26] frame_status, [31:29] zero
    output logic [M_TDATA_W-1:0]      m_tdata,
    // [2:0] byte_role, [3] is_ssid_byte
    output logic [M_TUSER_W-1:0]      m_tuser,
    output logic                      m_tlast,   // frame_done
    // Configuration write channel: max_info_length.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [COUNT_W-1:0]   cfg_data
);

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_CTRL,
        PH_PID,
        PH_INFO
    } phase_t;

    // Parse state.
    logic [BIA_W-1:0]    bia_reg,      bia_next;
    logic [ANUM_W-1:0]   addr_cnt_reg, addr_cnt_next;
    phase_t              phase_reg,    phase_next;
    logic [COUNT_W-1:0]  fbc_reg,      fbc_next;
    logic [COUNT_W-1:0]  info_cnt_reg, info_cnt_next;
    logic [STATUS_W-1:0] sticky_reg,   sticky_next;
    logic [HDR_W-1:0]    hdr_cnt_reg,  hdr_cnt_next;
    logic [COUNT_W-1:0]  max_info_reg;

    // Result register.
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg,  m_tdata_next;
    logic [M_TUSER_W-1:0]  m_tuser_reg,  m_tuser_next;
    logic                  m_tlast_reg;

    logic accept;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Tag the current byte and work out the next parse state.
    always_comb begin
        logic [ROLE_W-1:0]   role;
        logic [ANUM_W-1:0]   anum;
        logic [CHAR_W-1:0]   cs;
        logic [SSID_W-1:0]   ssid;
        logic                is_ssid;
        logic [ANUM_W-1:0]   addr_inc;
        logic [DIGI_W-1:0]   digis;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  limit;

        bia_next      = bia_reg;
        addr_cnt_next = addr_cnt_reg;
        phase_next    = phase_reg;
        info_cnt_next = info_cnt_reg;
        sticky_next   = sticky_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        role          = ROLE_INFO;
        anum          = '0;
        cs            = '0;
        ssid          = '0;
        is_ssid       = 1'b0;
        addr_inc      = addr_cnt_reg + ANUM_W'(1);
        limit         = (max_info_reg < INFO_CAP) ? max_info_reg : INFO_CAP;

        fbc_next = (fbc_reg != COUNT_MAX) ? fbc_reg + COUNT_W'(1) : fbc_reg;

        case (phase_reg)
            PH_ADDR: begin
                anum = addr_cnt_reg;
                if (addr_cnt_reg == ANUM_W'(0)) begin
                    role = ROLE_DEST;
                end else if (addr_cnt_reg == ANUM_W'(1)) begin
                    role = ROLE_SOURCE;
                end else begin
                    role = ROLE_DIGI;
                end
                if (bia_reg < BIA_W'(ADDRESS_BYTES - 1)) begin
                    cs       = s_tdata[7:1];
                    bia_next = bia_reg + BIA_W'(1);
                end else begin
                    // Seventh byte: SSID and the extension bit.
                    is_ssid       = 1'b1;
                    ssid          = s_tdata[4:1];
                    bia_next      = '0;
                    addr_cnt_next = addr_inc;
                    if (s_tdata[0]) begin
                        if (addr_inc < ANUM_W'(2) && sticky_reg == ST_OK) begin
                            sticky_next = ST_FEW;
                        end
                        phase_next = PH_CTRL;
                    end else if (addr_inc >= ANUM_W'(MAX_ADDRESSES)) begin
                        if (sticky_reg == ST_OK) begin
                            sticky_next = ST_OVER;
                        end
                        phase_next = PH_CTRL;
                    end
                end
                if (hdr_cnt_reg != HDR_MAX) begin
                    hdr_cnt_next = hdr_cnt_reg + HDR_W'(1);
                end
            end
            PH_CTRL: begin
                role       = ROLE_CONTROL;
                phase_next = PH_PID;
                if (hdr_cnt_reg != HDR_MAX) begin
                    hdr_cnt_next = hdr_cnt_reg + HDR_W'(1);
                end
            end
            PH_PID: begin
                role       = ROLE_PID;
                phase_next = PH_INFO;
                if (hdr_cnt_reg != HDR_MAX) begin
                    hdr_cnt_next = hdr_cnt_reg + HDR_W'(1);
                end
            end
            default: begin
                role = ROLE_INFO;
                if (info_cnt_reg != COUNT_MAX) begin
                    info_cnt_next = info_cnt_reg + COUNT_W'(1);
                end
                if (info_cnt_next > limit && sticky_reg == ST_OK) begin
                    sticky_next = ST_LONG;
                end
            end
        endcase

        // Digipeaters are the completed addresses beyond the second.
        digis = (addr_cnt_next > ANUM_W'(2)) ? addr_cnt_next - ANUM_W'(2) : '0;

        // A frame that ends before its PID byte, or is too short, reports short.
        status = sticky_next;
        if (s_tlast && (fbc_next < COUNT_W'(MIN_FRAME_LEN) || phase_next != PH_INFO)) begin
            status = ST_SHORT;
        end

        m_tdata_next = {3'b000, status, hdr_cnt_next, digis, ssid, cs, anum};
        m_tuser_next = {is_ssid, role};
    end

    // Parse state, configuration register and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bia_reg      <= '0;
            addr_cnt_reg <= '0;
            phase_reg    <= PH_ADDR;
            fbc_reg      <= '0;
            info_cnt_reg <= '0;
            sticky_reg   <= ST_OK;
            hdr_cnt_reg  <= '0;
            max_info_reg <= INFO_RESET_LIMIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                max_info_reg <= cfg_data;
            end
            if (accept) begin
                if (s_tlast) begin
                    // Frame end: back to the start of the address field.
                    bia_reg      <= '0;
                    addr_cnt_reg <= '0;
                    phase_reg    <= PH_ADDR;
                    fbc_reg      <= '0;
                    info_cnt_reg <= '0;
                    sticky_reg   <= ST_OK;
                    hdr_cnt_reg  <= '0;
                end else begin
                    bia_reg      <= bia_next;
                    addr_cnt_reg <= addr_cnt_next;
                    phase_reg    <= phase_next;
                    fbc_reg      <= fbc_next;
                    info_cnt_reg <= info_cnt_next;
                    sticky_reg   <= sticky_next;
                    hdr_cnt_reg  <= hdr_cnt_next;
                end
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded on every accepted beat.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
            m_tlast_reg <= s_tlast;
        end
    end

endmodule

`default_nettype wire
